// ===== design/srac_pkg.sv =====
// Shared types and constants for the sequential readahead controller.
// No dependencies; used by every module of the block.
package srac_pkg;

  localparam int SECTOR_SHIFT = 9;
  localparam int SECTOR_BYTES = 1 << SECTOR_SHIFT;
  localparam int DEFAULT_XFER_BYTES = 128 * 1024;

  localparam int LBA_W   = 32;
  localparam int CNT_W   = 13;
  localparam int BYTES_W = 21;

  localparam logic [CNT_W-1:0] XFER_DEFAULT = CNT_W'(DEFAULT_XFER_BYTES / SECTOR_BYTES);
  localparam logic [CNT_W-1:0] XFER_MIN     = CNT_W'(32);
  localparam logic [CNT_W-1:0] XFER_MAX     = CNT_W'(4096);

  localparam logic [1:0] REG_PART_START   = 2'd0;
  localparam logic [1:0] REG_PART_SECTORS = 2'd1;
  localparam logic [1:0] REG_XFER_LIMIT   = 2'd2;

  typedef enum logic [1:0] {
    ST_READ    = 2'd0,
    ST_WRITE   = 2'd1,
    ST_HIT     = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  typedef enum logic {
    FRONT_IDLE     = 1'b0,
    FRONT_CLASSIFY = 1'b1
  } front_state_t;

  typedef struct packed {
    logic [LBA_W-1:0] part_start;
    logic [LBA_W-1:0] part_sectors;
    logic [CNT_W-1:0] xfer_limit;
  } cfg_t;

  // One classified request, ready for the command issuer
  typedef struct packed {
    status_t          status;
    logic [LBA_W-1:0] lba;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] client;
    logic [CNT_W-1:0] offset;
    logic [CNT_W-1:0] xfer;
  } cmd_desc_t;

endpackage

// ===== design/srac_front.sv =====
// Front end: accepts requests, checks size, classifies hit/miss/write and
// keeps the readahead window. Depends on srac_pkg.
module srac_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_mode,
  input  logic [srac_pkg::LBA_W-1:0]     in_record,
  input  logic [srac_pkg::BYTES_W-1:0]   in_byte_count,
  input  srac_pkg::cfg_t                 cfg,
  output logic                           push_valid,
  input  logic                           push_ready,
  output srac_pkg::cmd_desc_t            push_desc
);

  localparam int LW = srac_pkg::LBA_W;
  localparam int CW = srac_pkg::CNT_W;

  srac_pkg::front_state_t state_r, state_nxt;

  logic          mode_r;
  logic [LW-1:0] rec_r;
  logic [CW-1:0] n_r;
  logic [LW-1:0] lba_r;

  logic          win_valid_r, win_valid_nxt;
  logic [LW-1:0] win_start_r, win_start_nxt;
  logic [CW-1:0] win_count_r, win_count_nxt;

  logic [srac_pkg::BYTES_W:0] bytes_round;
  logic [CW-1:0] xfer;
  logic          bad_size;
  logic          hit;
  logic          seq;
  logic [LW-1:0] seq_at;
  logic          push_fire;

  assign bytes_round = {1'b0, in_byte_count} + (srac_pkg::BYTES_W+1)'(srac_pkg::SECTOR_BYTES - 1);

  always_comb begin
    if (cfg.xfer_limit == '0) begin
      xfer = srac_pkg::XFER_DEFAULT;
    end else if (cfg.xfer_limit < srac_pkg::XFER_MIN) begin
      xfer = srac_pkg::XFER_MIN;
    end else if (cfg.xfer_limit > srac_pkg::XFER_MAX) begin
      xfer = srac_pkg::XFER_MAX;
    end else begin
      xfer = cfg.xfer_limit;
    end
  end

  assign bad_size = (n_r == '0) ||
                    (({1'b0, rec_r} + {{(LW+1-CW){1'b0}}, n_r}) > {1'b0, cfg.part_sectors});
  assign hit = win_valid_r && (lba_r >= win_start_r) &&
               (({1'b0, lba_r} + {{(LW+1-CW){1'b0}}, n_r}) <=
                ({1'b0, win_start_r} + {{(LW+1-CW){1'b0}}, win_count_r}));
  assign seq_at = win_start_r + {{(LW-CW){1'b0}}, win_count_r};
  assign seq = (lba_r == seq_at) && (n_r <= (xfer >> 1)) &&
               (({1'b0, rec_r} + {{(LW+1-CW){1'b0}}, xfer}) <= {1'b0, cfg.part_sectors});

  always_comb begin
    push_desc        = '0;
    push_desc.xfer   = xfer;
    push_desc.status = srac_pkg::ST_INVALID;
    if (!bad_size) begin
      push_desc.lba   = lba_r;
      push_desc.total = n_r;
      if (mode_r) begin
        push_desc.status = srac_pkg::ST_WRITE;
      end else if (hit) begin
        push_desc.status = srac_pkg::ST_HIT;
        push_desc.client = n_r;
        push_desc.offset = CW'(lba_r - win_start_r);
      end else begin
        push_desc.status = srac_pkg::ST_READ;
        push_desc.client = n_r;
        if (seq) begin
          push_desc.total = xfer;
        end
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    push_valid = 1'b0;
    case (state_r)
      srac_pkg::FRONT_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = srac_pkg::FRONT_CLASSIFY;
        end
      end
      srac_pkg::FRONT_CLASSIFY: begin
        push_valid = 1'b1;
        if (push_ready) begin
          state_nxt = srac_pkg::FRONT_IDLE;
        end
      end
      default: state_nxt = srac_pkg::FRONT_IDLE;
    endcase
  end

  assign push_fire = push_valid && push_ready;

  // Window follows the request only once it has been handed to the queue
  always_comb begin
    win_valid_nxt = win_valid_r;
    win_start_nxt = win_start_r;
    win_count_nxt = win_count_r;
    if (push_fire && !bad_size) begin
      if (mode_r) begin
        if (win_valid_r) begin
          win_valid_nxt = 1'b0;
          win_count_nxt = '0;
        end
      end else if (!hit) begin
        if (seq) begin
          win_valid_nxt = 1'b1;
          win_start_nxt = lba_r + {{(LW-CW){1'b0}}, n_r};
          win_count_nxt = xfer - n_r;
        end else begin
          win_valid_nxt = 1'b0;
          win_start_nxt = lba_r;
          win_count_nxt = n_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srac_pkg::FRONT_IDLE;
      win_valid_r <= 1'b0;
      win_start_r <= '0;
      win_count_r <= '0;
    end else begin
      state_r     <= state_nxt;
      win_valid_r <= win_valid_nxt;
      win_start_r <= win_start_nxt;
      win_count_r <= win_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r <= in_mode;
      rec_r  <= in_record;
      n_r    <= CW'(bytes_round >> srac_pkg::SECTOR_SHIFT);
      lba_r  <= cfg.part_start + in_record;
    end
  end

  // A valid window always holds readahead sectors
  a_window_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    win_valid_r |-> (win_count_r != '0))
    else $error("valid readahead window is empty");

endmodule

// ===== design/srac_queue.sv =====
// Two-entry queue of classified requests between front end and issuer.
// Depends on srac_pkg.
module srac_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  srac_pkg::cmd_desc_t  push_desc,
  output logic                 pop_valid,
  input  logic                 pop,
  output srac_pkg::cmd_desc_t  pop_desc
);

  localparam int DEPTH = 2;

  srac_pkg::cmd_desc_t slots_r [DEPTH];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push, do_pop;

  assign push_ready = (count_r != 2'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_desc   = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_desc;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'(DEPTH))
    else $error("queue count out of range");

endmodule

// ===== design/srac_back.sv =====
// Command issuer: splits each queued request into disk commands, one per
// cycle unless out_ready stalls it, into the output register. Depends on srac_pkg.
module srac_back #(
  parameter int MAX_CHUNKS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  srac_pkg::cmd_desc_t          q_desc,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_status,
  output logic [srac_pkg::LBA_W-1:0]   out_disk_lba,
  output logic [srac_pkg::CNT_W-1:0]   out_sector_count,
  output logic [srac_pkg::CNT_W-1:0]   out_client_sectors,
  output logic [srac_pkg::CNT_W-1:0]   out_cache_offset,
  output logic                         out_last
);

  localparam int LW = srac_pkg::LBA_W;
  localparam int CW = srac_pkg::CNT_W;
  localparam int KW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam logic [KW-1:0] K_LAST = KW'(MAX_CHUNKS - 1);

  logic [CW-1:0] off_r;
  logic [KW-1:0] k_r;
  logic          out_valid_r;
  logic [1:0]    status_r;
  logic [LW-1:0] lba_r;
  logic [CW-1:0] count_r, client_r, offset_r;
  logic          last_r;

  logic          single;
  logic [CW-1:0] rem;
  logic          final_chunk;
  logic [CW-1:0] chunk;
  logic [CW-1:0] client_left;
  logic [CW-1:0] chunk_client;
  logic          load;

  assign single = (q_desc.status == srac_pkg::ST_HIT) ||
                  (q_desc.status == srac_pkg::ST_INVALID);
  assign rem         = q_desc.total - off_r;
  assign final_chunk = single || (k_r == K_LAST) || (rem <= q_desc.xfer);
  assign chunk       = (final_chunk) ? rem : q_desc.xfer;
  assign client_left = q_desc.client - off_r;

  always_comb begin
    chunk_client = '0;
    if (q_desc.status == srac_pkg::ST_READ && off_r < q_desc.client) begin
      chunk_client = (client_left > chunk) ? chunk : client_left;
    end
  end

  assign load  = q_valid && (!out_valid_r || out_ready);
  assign q_pop = load && final_chunk;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      off_r       <= '0;
      k_r         <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop) begin
        off_r <= '0;
        k_r   <= '0;
      end else if (load) begin
        off_r <= off_r + chunk;
        k_r   <= k_r + KW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= q_desc.status;
      last_r   <= final_chunk;
      if (single) begin
        lba_r    <= q_desc.lba;
        count_r  <= q_desc.total;
        client_r <= q_desc.client;
        offset_r <= q_desc.offset;
      end else begin
        lba_r    <= q_desc.lba + {{(LW-CW){1'b0}}, off_r};
        count_r  <= chunk;
        client_r <= chunk_client;
        offset_r <= '0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_disk_lba       = lba_r;
  assign out_sector_count   = count_r;
  assign out_client_sectors = client_r;
  assign out_cache_offset   = offset_r;
  assign out_last           = last_r;

  // Chunk walk never runs past the end of the transfer
  a_off_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && !single) |-> (off_r < q_desc.total))
    else $error("chunk offset past transfer end");

  // Offset counter is idle whenever nothing is queued
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |-> (off_r == '0 && k_r == '0))
    else $error("chunk counters not cleared between requests");

  // A write command never hands sectors to the requester
  a_write_no_client: assert property (@(posedge clk) disable iff (!rst_n)
    (load && q_desc.status == srac_pkg::ST_WRITE) |=> (client_r == '0))
    else $error("write command carries client sectors");

endmodule

// ===== design/sequential_readahead_controller_top.sv =====
// Top level of the sequential readahead controller: configuration
// registers, front end, request queue and command issuer.
// Depends on srac_pkg, srac_front, srac_queue, srac_back.
//
// Usage: requests (mode, record, byte_count) enter on the in_ channel with
// a valid/ready handshake; each request yields one or more results on the
// out_ channel, the final one flagged by out_last. Reads that hit the
// readahead window and rejected requests give a single result; misses and
// writes give one disk command per chunk of at most the transfer size; the
// last allowed chunk takes the rest. Timing: the front end captures a
// request, then classifies it and hands it to the queue; the first result
// of a request passes the capture registers, a queue slot and the output
// register. The issuer puts out one result per cycle while out_ready does
// not stall it, so a request with several results holds the issuer until
// its last chunk is out. A two-entry queue lets the front end classify the
// next request while the issuer is still busy.
// When out_ready is low the output register holds; the issuer and then
// the queue fill, and in_ready falls. Reset (synchronous, rst_n low)
// clears the window and restores the register defaults; there is no
// clearing pass. Write cfg_ registers only while the block is idle.
module sequential_readahead_controller_top #(
  parameter int MAX_CHUNKS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [31:0]                  cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_mode,
  input  logic [srac_pkg::LBA_W-1:0]   in_record,
  input  logic [srac_pkg::BYTES_W-1:0] in_byte_count,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_status,
  output logic [srac_pkg::LBA_W-1:0]   out_disk_lba,
  output logic [srac_pkg::CNT_W-1:0]   out_sector_count,
  output logic [srac_pkg::CNT_W-1:0]   out_client_sectors,
  output logic [srac_pkg::CNT_W-1:0]   out_cache_offset,
  output logic                         out_last
);

  srac_pkg::cfg_t      cfg_r;
  srac_pkg::cmd_desc_t push_desc, pop_desc;
  logic                push_valid, push_ready;
  logic                pop_valid, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.part_start   <= '0;
      cfg_r.part_sectors <= '0;
      cfg_r.xfer_limit   <= srac_pkg::CNT_W'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        srac_pkg::REG_PART_START:   cfg_r.part_start   <= cfg_wdata;
        srac_pkg::REG_PART_SECTORS: cfg_r.part_sectors <= cfg_wdata;
        srac_pkg::REG_XFER_LIMIT:   cfg_r.xfer_limit   <= cfg_wdata[srac_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  srac_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_record     (in_record),
    .in_byte_count (in_byte_count),
    .cfg           (cfg_r),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_desc     (push_desc)
  );

  srac_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_desc   (pop_desc)
  );

  srac_back #(
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (pop_valid),
    .q_desc             (pop_desc),
    .q_pop              (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_disk_lba       (out_disk_lba),
    .out_sector_count   (out_sector_count),
    .out_client_sectors (out_client_sectors),
    .out_cache_offset   (out_cache_offset),
    .out_last           (out_last)
  );

endmodule

// ===== tb/sv/srac_command_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the sequential readahead controller: tracks config
// writes and request transfers, predicts disk commands and compares them.
// Depends on srac_pkg for field widths, status codes and register indexes.
module srac_command_checker #(
  parameter int CHUNK_LIMIT = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [31:0]                  cfg_wdata,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic                         in_mode,
  input  logic [srac_pkg::LBA_W-1:0]   in_record,
  input  logic [srac_pkg::BYTES_W-1:0] in_byte_count,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [1:0]                   out_status,
  input  logic [srac_pkg::LBA_W-1:0]   out_disk_lba,
  input  logic [srac_pkg::CNT_W-1:0]   out_sector_count,
  input  logic [srac_pkg::CNT_W-1:0]   out_client_sectors,
  input  logic [srac_pkg::CNT_W-1:0]   out_cache_offset,
  input  logic                         out_last,
  output int                           mismatches,
  output int                           pending
);

  localparam int LW = srac_pkg::LBA_W;
  localparam int CW = srac_pkg::CNT_W;

  typedef struct packed {
    srac_pkg::status_t status;
    logic [LW-1:0]     lba;
    logic [CW-1:0]     count;
    logic [CW-1:0]     client;
    logic [CW-1:0]     offset;
    logic              last;
  } disk_cmd_t;

  disk_cmd_t expected_cmds[$];
  disk_cmd_t head;

  logic [LW-1:0] part_base;
  logic [LW-1:0] part_span;
  logic [CW-1:0] xfer_reg;

  logic          win_valid;
  logic [LW-1:0] win_start;
  logic [CW-1:0] win_count;

  int fail_total = 0;
  int backlog = 0;

  assign mismatches = fail_total;
  assign pending    = backlog;

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
    fail_total++;
  endtask

  // Split total sectors into commands; the last allowed chunk takes the rest
  task automatic queue_chunks(input srac_pkg::status_t kind, input logic [LW-1:0] lba,
                              input longint unsigned total,
                              input longint unsigned client,
                              input longint unsigned xfer);
    longint unsigned off;
    longint unsigned c;
    longint unsigned cl;
    int k;
    disk_cmd_t cmd;
    off = 0;
    k = 0;
    while (off < total) begin
      c = total - off;
      if (k != CHUNK_LIMIT - 1 && c > xfer) c = xfer;
      cl = 0;
      if (kind == srac_pkg::ST_READ && off < client) begin
        cl = client - off;
        if (cl > c) cl = c;
      end
      cmd.status = kind;
      cmd.lba    = LW'(lba + off);
      cmd.count  = CW'(c);
      cmd.client = CW'(cl);
      cmd.offset = '0;
      cmd.last   = (off + c >= total);
      expected_cmds.push_back(cmd);
      off += c;
      k++;
    end
  endtask

  task automatic predict_commands(input logic is_write, input logic [LW-1:0] rec,
                                  input logic [srac_pkg::BYTES_W-1:0] bc);
    longint unsigned n;
    longint unsigned xfer;
    longint unsigned total;
    longint unsigned req_end;
    longint unsigned win_end;
    logic [LW-1:0] lba;
    logic [LW-1:0] seq_at;
    disk_cmd_t cmd;
    n = (longint'(bc) + srac_pkg::SECTOR_BYTES - 1) / srac_pkg::SECTOR_BYTES;
    xfer = xfer_reg;
    if (xfer == 0) xfer = srac_pkg::XFER_DEFAULT;
    if (xfer < srac_pkg::XFER_MIN) xfer = srac_pkg::XFER_MIN;
    if (xfer > srac_pkg::XFER_MAX) xfer = srac_pkg::XFER_MAX;
    lba = part_base + rec;
    req_end = longint'(lba) + n;
    win_end = longint'(win_start) + win_count;
    cmd = '0;
    cmd.last = 1'b1;
    if (n == 0 || longint'(rec) + n > longint'(part_span)) begin
      cmd.status = srac_pkg::ST_INVALID;
      expected_cmds.push_back(cmd);
    end else if (is_write) begin
      if (win_valid) begin
        win_valid = 1'b0;
        win_count = '0;
      end
      queue_chunks(srac_pkg::ST_WRITE, lba, n, 0, xfer);
    end else if (win_valid && lba >= win_start && req_end <= win_end) begin
      cmd.status = srac_pkg::ST_HIT;
      cmd.lba    = lba;
      cmd.count  = CW'(n);
      cmd.client = CW'(n);
      cmd.offset = CW'(lba - win_start);
      expected_cmds.push_back(cmd);
    end else begin
      seq_at = win_start + win_count;
      total = n;
      // widen a small read that continues the last one, valid window or not
      if (lba == seq_at && n <= xfer / 2 && longint'(rec) + xfer <= longint'(part_span))
        total = xfer;
      queue_chunks(srac_pkg::ST_READ, lba, total, n, xfer);
      win_valid = (total > n);
      win_start = win_valid ? LW'(lba + n) : lba;
      win_count = win_valid ? CW'(total - n) : CW'(n);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      part_base = '0;
      part_span = '0;
      xfer_reg  = CW'(256);
      win_valid = 1'b0;
      win_start = '0;
      win_count = '0;
      expected_cmds.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          srac_pkg::REG_PART_START:   part_base = cfg_wdata;
          srac_pkg::REG_PART_SECTORS: part_span = cfg_wdata;
          srac_pkg::REG_XFER_LIMIT:   xfer_reg  = cfg_wdata[CW-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_commands(in_mode, in_record, in_byte_count);
      if (out_valid && out_ready) begin
        if (expected_cmds.size() == 0) begin
          flag_mismatch("unrequested result, lba", out_disk_lba, 0);
        end else begin
          head = expected_cmds.pop_front();
          if (out_status !== head.status) flag_mismatch("status", out_status, head.status);
          if (out_disk_lba !== head.lba) flag_mismatch("disk_lba", out_disk_lba, head.lba);
          if (out_sector_count !== head.count)
            flag_mismatch("sector_count", out_sector_count, head.count);
          if (out_client_sectors !== head.client)
            flag_mismatch("client_sectors", out_client_sectors, head.client);
          if (out_cache_offset !== head.offset)
            flag_mismatch("cache_offset", out_cache_offset, head.offset);
          if (out_last !== head.last) flag_mismatch("last", out_last, head.last);
        end
      end
    end
    backlog <= expected_cmds.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Top of the readahead controller testbench: clock, reset, register setup,
// request stimulus and result back-pressure, plus the final verdict.
// Depends on srac_pkg, sequential_readahead_controller_top, srac_command_checker.
module testbench;

  localparam int CHUNK_LIMIT = 64;
  localparam int LW = srac_pkg::LBA_W;
  localparam int BW = srac_pkg::BYTES_W;
  localparam int CW = srac_pkg::CNT_W;

  logic          clk = 1'b0;
  logic          rst_n;
  logic          cfg_we;
  logic [1:0]    cfg_index;
  logic [31:0]   cfg_wdata;
  logic          in_valid;
  logic          in_ready;
  logic          in_mode;
  logic [LW-1:0] in_record;
  logic [BW-1:0] in_byte_count;
  logic          out_valid;
  logic          out_ready;
  logic [1:0]    out_status;
  logic [LW-1:0] out_disk_lba;
  logic [CW-1:0] out_sector_count;
  logic [CW-1:0] out_client_sectors;
  logic [CW-1:0] out_cache_offset;
  logic          out_last;

  int mismatches;
  int pending;
  bit gaps_on = 1'b1;
  bit choke_out = 1'b0;
  bit choke_done = 1'b0;

  always #10 clk = ~clk;

  sequential_readahead_controller_top #(.MAX_CHUNKS(CHUNK_LIMIT)) dut (.*);

  srac_command_checker #(.CHUNK_LIMIT(CHUNK_LIMIT)) u_checker (.*);

  task automatic send_request(input logic mode, input logic [LW-1:0] rec,
                              input logic [BW-1:0] bc);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_record     <= rec;
    in_byte_count <= bc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and let every outstanding command drain
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_regs(input logic [31:0] start, input logic [31:0] sectors,
                            input logic [31:0] xfer);
    cfg_we    <= 1'b1;
    cfg_index <= srac_pkg::REG_PART_START;
    cfg_wdata <= start;
    @(posedge clk);
    cfg_index <= srac_pkg::REG_PART_SECTORS;
    cfg_wdata <= sectors;
    @(posedge clk);
    cfg_index <= srac_pkg::REG_XFER_LIMIT;
    cfg_wdata <= xfer;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly streaming reads so readahead windows form, mixed with rereads,
  // writes, scattered reads, rejects and large transfers
  task automatic random_phase(input int count, input logic [31:0] sectors,
                              input int stream_max);
    longint unsigned cursor;
    int unsigned nsec;
    int unsigned pick;
    logic [LW-1:0] rec;
    logic [BW-1:0] bc;
    logic mode;
    cursor = $urandom_range(0, sectors - stream_max);
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      mode = 1'b0;
      nsec = $urandom_range(1, 64);
      rec  = $urandom_range(0, sectors - 64);
      if (pick < 50) begin
        nsec = $urandom_range(1, stream_max);
        if (cursor + nsec > sectors) cursor = $urandom_range(0, sectors - stream_max);
        rec = LW'(cursor);
        cursor += nsec;
      end else if (pick < 60) begin
        nsec = $urandom_range(1, 8);
        rec  = LW'(cursor - $urandom_range(0, (cursor > 64) ? 64 : cursor));
      end else if (pick < 75) begin
        mode = 1'b1;
      end else if (pick < 93 && pick >= 85) begin
        rec  = $urandom();
        nsec = $urandom_range(0, 1) ? 0 : $urandom_range(1, 2048);
      end
      if (pick >= 93) begin
        mode = 1'($urandom_range(0, 1));
        bc   = BW'($urandom_range(0, 1048576));
      end else if (nsec == 0) begin
        bc = '0;
      end else begin
        bc = BW'((nsec - 1) * srac_pkg::SECTOR_BYTES
                 + $urandom_range(1, srac_pkg::SECTOR_BYTES));
      end
      send_request(mode, rec, bc);
    end
  endtask

  // Result side: random short stalls, and one long hold on request
  initial begin
    out_ready <= 1'b0;
    forever begin
      if (choke_out && !choke_done) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        choke_done = 1'b1;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= srac_pkg::REG_PART_START;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    in_mode       <= 1'b0;
    in_record     <= '0;
    in_byte_count <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: an empty partition rejects everything
    send_request(1'b0, 32'd0, 21'd512);
    send_request(1'b1, 32'hFFFF_FFFF, 21'd1048576);
    settle();

    // zero transfer register selects the 128 KiB default
    write_regs(32'd0, 32'd100000, 32'd0);
    send_request(1'b0, 32'd0, 21'd1);           // sequential straight after reset
    send_request(1'b0, 32'd1, 21'd130560);      // hit covering the whole window
    send_request(1'b0, 32'd100, 21'd512);       // hit inside the window
    send_request(1'b0, 32'd256, 21'd1000);      // continue at window end
    send_request(1'b1, 32'd300, 21'd513);       // write kills a valid window
    send_request(1'b0, 32'd258, 21'd512);       // sequential after a write
    send_request(1'b0, 32'd0, 21'd0);           // empty request
    send_request(1'b0, 32'd99999, 21'd1024);    // runs one past the end
    send_request(1'b0, 32'd99999, 21'd512);     // ends exactly at the end
    send_request(1'b0, 32'hFFFF_FFFF, 21'd1048576);
    send_request(1'b0, 32'd1000, 21'd1048576);  // 2048-sector read, chunked
    send_request(1'b1, 32'd5000, 21'd1048576);  // 2048-sector write, invalid window
    send_request(1'b0, 32'd3048, 21'd512);
    send_request(1'b0, 32'd3304, 21'd66048);    // one sector over half a transfer
    send_request(1'b0, 32'd3433, 21'd65536);    // exactly half a transfer
    send_request(1'b0, 32'd3600, 21'd511);
    send_request(1'b0, 32'd3680, 21'd5120);     // straddles the window end
    settle();

    // sequential, but the widened read would pass the partition end
    write_regs(32'd0, 32'd3700, 32'd0);
    send_request(1'b0, 32'd3690, 21'd512);
    settle();

    write_regs($urandom(), 32'hFFFF_FFFF, 32'd32);
    choke_out = 1'b1;
    random_phase(70, 32'hFFFF_FFFF, 16);
    settle();

    write_regs(32'hFFFF_FFF0, 32'd1000000, 32'd4096);
    random_phase(70, 32'd1000000, 2048);
    settle();

    // below the minimum: saturates up, many small chunks
    write_regs(32'd0, 32'd5000, 32'd10);
    random_phase(70, 32'd5000, 16);
    settle();

    write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    random_phase(70, 32'hFFFF_FFFF, 128);
    settle();

    // above the maximum: saturates down; no idling from here on
    gaps_on = 1'b0;
    write_regs($urandom(), 32'd20000, 32'd8191);
    random_phase(70, 32'd20000, 2048);
    settle();

    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
